// ===== rtl/slpt_pkg.sv =====
// ----------------------------------------------------------------------------
// slpt_pkg: shared types and constants of the sound level peak tracker
// Register indexes, sequencer steps, the control word and the microcode
// table that drives the datapath.
// ----------------------------------------------------------------------------
package slpt_pkg;

	localparam int DEF_RING_DEPTH  = 8;
	localparam int DEF_SAMPLE_BITS = 10;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int WIN_LEN_W  = 16;
	localparam int WIN_CNT_W  = 17;
	localparam int LEVEL_W    = 16;
	localparam int Q15_FRAC   = 15;

	localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = 16'd1000;
	localparam logic [LEVEL_W-1:0]   Q15_ONE       = 16'h8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PEAK_WINDOW_LEN = 4'd0,
		REG_PEAK_FLOOR      = 4'd1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE     = 4'd0,
		ST_READ     = 4'd1,
		ST_UPDATE   = 4'd2,
		ST_READ_NEW = 4'd3,
		ST_NEW_SLOT = 4'd4,
		ST_SAT_TEST = 4'd5,
		ST_RAT_GO   = 4'd6,
		ST_RAT_WAIT = 4'd7,
		ST_RAT_ONE  = 4'd8,
		ST_OUT      = 4'd9
	} step_t;

	typedef enum logic [2:0] {
		JC_NEXT,
		JC_ALWAYS,
		JC_NO_ADV,
		JC_SAT,
		JC_START
	} jump_t;

	typedef enum logic [1:0] {
		DIV_NONE,
		DIV_RATIO
	} div_sel_t;

	typedef struct packed {
		logic     rd_en;
		logic     upd;
		logic     new_slot;
		div_sel_t div_sel;
		logic     div_wait;
		logic     lat_avg;
		logic     lat_ratio;
		logic     set_one;
		logic     out_load;
		jump_t    jc;
		step_t    target;
	} ctrl_t;

	function automatic ctrl_t ucode(step_t st);
		ctrl_t cw;
		cw = '0;
		cw.jc = JC_NEXT;
		cw.target = ST_IDLE;
		unique case (st)
			ST_IDLE: begin
				cw.jc = JC_START;
			end
			ST_READ: begin
				cw.rd_en = 1'b1;
			end
			ST_UPDATE: begin
				cw.upd = 1'b1;
				cw.jc = JC_NO_ADV;
				cw.target = ST_SAT_TEST;
			end
			ST_READ_NEW: begin
				cw.rd_en = 1'b1;
			end
			ST_NEW_SLOT: begin
				cw.new_slot = 1'b1;
			end
			ST_SAT_TEST: begin
				cw.lat_avg = 1'b1;
				cw.jc = JC_SAT;
				cw.target = ST_RAT_ONE;
			end
			ST_RAT_GO: begin
				cw.div_sel = DIV_RATIO;
			end
			ST_RAT_WAIT: begin
				cw.div_wait = 1'b1;
				cw.lat_ratio = 1'b1;
				cw.jc = JC_ALWAYS;
				cw.target = ST_OUT;
			end
			ST_RAT_ONE: begin
				cw.set_one = 1'b1;
			end
			ST_OUT: begin
				cw.out_load = 1'b1;
				cw.jc = JC_ALWAYS;
				cw.target = ST_IDLE;
			end
			default: begin
				cw.jc = JC_ALWAYS;
				cw.target = ST_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage

// ===== rtl/slpt_channels.sv =====
// ----------------------------------------------------------------------------
// slpt channels: valid/ready interfaces of the sound level peak tracker
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface slpt_sample_if
	import slpt_pkg::*;
#(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface slpt_result_if
	import slpt_pkg::*;
#(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] raw_level;
	logic [SAMPLE_BITS-1:0] average_level;
	logic [SAMPLE_BITS-1:0] magnitude;
	logic [LEVEL_W-1:0]     adjusted_level;

	modport source (output valid, output raw_level, output average_level,
		output magnitude, output adjusted_level, input ready);
	modport sink (input valid, input raw_level, input average_level,
		input magnitude, input adjusted_level, output ready);
endinterface

interface slpt_cfg_if
	import slpt_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/slpt_div.sv =====
// ----------------------------------------------------------------------------
// slpt_div: restoring divider for the sum ratio
// One quotient bit per cycle. The remainder starts at rem_init, which is below
// the divisor, and is doubled at each step, most significant bit first.
// ----------------------------------------------------------------------------
module slpt_div
	import slpt_pkg::*;
#(
	parameter int SUM_W = 13,
	parameter int Q_W   = 16,
	parameter int CNT_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] rem_init,
	input  logic [CNT_W-1:0] steps,
	input  logic [SUM_W-1:0] den,
	output logic             busy,
	output logic [Q_W-1:0]   quot
);

	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] den_q;
	logic [Q_W-1:0]   quot_q;
	logic [SUM_W:0]   rem_x;
	logic [SUM_W:0]   rem_d;
	logic             fits;

	assign busy  = (cnt_q != '0);
	assign quot  = quot_q;
	assign rem_x = {rem_q, 1'b0};
	assign fits  = (rem_x >= {1'b0, den_q});
	assign rem_d = rem_x - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= steps;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy) begin
			// The remainder stays below the divisor, so it fits back in SUM_W bits.
			rem_q  <= fits ? rem_d[SUM_W-1:0] : rem_x[SUM_W-1:0];
			quot_q <= {quot_q[Q_W-2:0], fits};
		end
	end

endmodule

// ===== rtl/sound_level_peak_tracker.sv =====
// ----------------------------------------------------------------------------
// sound_level_peak_tracker: moving average with windowed peak hold
// Microcoded sequencer over two sample rings, running sums and a divider.
// ----------------------------------------------------------------------------
// Each nonzero sample transfer produces one result transfer; a zero sample is
// taken and dropped. One sample is processed at a time: the input is ready
// again in the same cycle as the result is offered. The restoring divider
// runs 15 steps for the Q1.15 ratio, which is set to one without the divider
// when it saturates. The average is the ring sum shifted right, so RING_DEPTH
// must be a power of two. A result that is not taken holds the sequencer in
// its output step. The rings reset to zero through per-entry valid bits, so
// no clearing pass is needed. Configuration writes are always taken and
// should be made while idle.
module sound_level_peak_tracker
	import slpt_pkg::*;
#(
	parameter int RING_DEPTH  = DEF_RING_DEPTH,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input logic          clk,
	input logic          arst_n,
	slpt_sample_if.sink  samples,
	slpt_result_if.source results,
	slpt_cfg_if.sink     cfg
);

	localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int SUM_W  = SAMPLE_BITS + $clog2(RING_DEPTH);
	localparam int Q_W    = (SUM_W > LEVEL_W) ? SUM_W : LEVEL_W;
	localparam int CNT_W  = $clog2(Q_W + 1);
	localparam int EXT_W  = SUM_W - SAMPLE_BITS;

	// configuration
	logic [WIN_LEN_W-1:0]   win_len_q;
	logic [SAMPLE_BITS-1:0] floor_q;

	// sequencer
	step_t step_q;
	step_t step_d;
	ctrl_t cw;
	logic  start;
	logic  hold;
	logic  sat;

	// datapath
	logic [SAMPLE_BITS-1:0] s_q;
	logic [SAMPLE_BITS-1:0] sample_mem [RING_DEPTH];
	logic [SAMPLE_BITS-1:0] peak_mem [RING_DEPTH];
	logic [RING_DEPTH-1:0]  s_vld_q;
	logic [RING_DEPTH-1:0]  p_vld_q;
	logic [SAMPLE_BITS-1:0] rd_s_q;
	logic [SAMPLE_BITS-1:0] rd_p_q;
	logic                   rd_s_vld_q;
	logic                   rd_p_vld_q;
	logic [SAMPLE_BITS-1:0] old_s;
	logic [SAMPLE_BITS-1:0] old_p;
	logic [SLOT_W-1:0]      ws_q;
	logic [SLOT_W-1:0]      ps_q;
	logic [SLOT_W-1:0]      ps_next;
	logic [WIN_CNT_W-1:0]   wc_q;
	logic                   win_over;
	logic                   raise;
	logic [SUM_W-1:0]       sample_sum_q;
	logic [SUM_W-1:0]       peak_sum_q;
	logic [SAMPLE_BITS-1:0] avg_q;
	logic [LEVEL_W-1:0]     ratio_q;

	// divider
	logic             div_start;
	logic [SUM_W-1:0] div_rem;
	logic [CNT_W-1:0] div_steps;
	logic [SUM_W-1:0] div_den;
	logic             div_busy;
	logic [Q_W-1:0]   div_quot;

	// output register
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_raw_q;
	logic [SAMPLE_BITS-1:0] out_avg_q;
	logic [SAMPLE_BITS-1:0] out_mag_q;
	logic [LEVEL_W-1:0]     out_adj_q;
	logic                   out_load;

	// ------------------------------------------------------------------
	// Configuration writes
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= WIN_LEN_RESET;
			floor_q   <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PEAK_WINDOW_LEN: win_len_q <= cfg.data[WIN_LEN_W-1:0];
				REG_PEAK_FLOOR:      floor_q   <= cfg.data[SAMPLE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequencer: step counter, microcode table and conditional jumps
	// ------------------------------------------------------------------
	assign samples.ready = (step_q == ST_IDLE);
	assign start = samples.valid && (step_q == ST_IDLE) && (samples.sample != '0);
	assign sat   = (peak_sum_q == '0) || (sample_sum_q >= peak_sum_q);

	always_comb begin
		cw = ucode(step_q);
	end

	always_comb begin
		hold = (cw.div_wait && div_busy) || (cw.out_load && out_valid_q && !results.ready);
		step_d = step_q;
		if (!hold) begin
			unique case (cw.jc)
				JC_NEXT:   step_d = step_t'(step_q + 4'd1);
				JC_ALWAYS: step_d = cw.target;
				JC_NO_ADV: step_d = win_over ? step_t'(step_q + 4'd1) : cw.target;
				JC_SAT:    step_d = sat ? cw.target : step_t'(step_q + 4'd1);
				JC_START:  step_d = start ? step_t'(step_q + 4'd1) : step_q;
				default:   step_d = ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// ------------------------------------------------------------------
	// Rings: read data registered, an entry never written reads as zero
	// ------------------------------------------------------------------
	assign old_s    = rd_s_vld_q ? rd_s_q : '0;
	assign old_p    = rd_p_vld_q ? rd_p_q : '0;
	assign raise    = (s_q > old_p);
	assign win_over = (wc_q > {1'b0, win_len_q});
	assign ps_next  = (ps_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : ps_q + 1'b1;

	always_ff @(posedge clk) begin
		if (start) begin
			s_q <= samples.sample;
		end
		if (cw.rd_en) begin
			rd_s_q <= sample_mem[ws_q];
			rd_p_q <= peak_mem[ps_q];
		end
		if (cw.upd) begin
			sample_mem[ws_q] <= s_q;
		end
		if (cw.upd && raise) begin
			peak_mem[ps_q] <= s_q;
		end else if (cw.new_slot) begin
			peak_mem[ps_q] <= floor_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_vld_q      <= '0;
			p_vld_q      <= '0;
			rd_s_vld_q   <= 1'b0;
			rd_p_vld_q   <= 1'b0;
			ws_q         <= '0;
			ps_q         <= '0;
			wc_q         <= '0;
			sample_sum_q <= '0;
			peak_sum_q   <= '0;
		end else begin
			if (cw.rd_en) begin
				rd_s_vld_q <= s_vld_q[ws_q];
				rd_p_vld_q <= p_vld_q[ps_q];
			end
			if (cw.upd) begin
				s_vld_q[ws_q] <= 1'b1;
				sample_sum_q  <= sample_sum_q - {{EXT_W{1'b0}}, old_s}
					+ {{EXT_W{1'b0}}, s_q};
				ws_q <= (ws_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : ws_q + 1'b1;
				if (raise) begin
					p_vld_q[ps_q] <= 1'b1;
					peak_sum_q    <= peak_sum_q - {{EXT_W{1'b0}}, old_p}
						+ {{EXT_W{1'b0}}, s_q};
				end
				// The window counter is compared before it is incremented.
				if (win_over) begin
					wc_q <= '0;
					ps_q <= ps_next;
				end else begin
					wc_q <= wc_q + 1'b1;
				end
			end
			if (cw.new_slot) begin
				p_vld_q[ps_q] <= 1'b1;
				peak_sum_q    <= peak_sum_q - {{EXT_W{1'b0}}, old_p}
					+ {{EXT_W{1'b0}}, floor_q};
			end
		end
	end

	// ------------------------------------------------------------------
	// Divider for the Q1.15 sum ratio
	// ------------------------------------------------------------------
	always_comb begin
		div_start = 1'b0;
		div_rem   = '0;
		div_steps = '0;
		div_den   = '0;
		case (cw.div_sel)
			DIV_RATIO: begin
				// The sample sum is below the peak sum here, so it is a valid remainder.
				div_start = 1'b1;
				div_rem   = sample_sum_q;
				div_steps = CNT_W'(Q15_FRAC);
				div_den   = peak_sum_q;
			end
			default: ;
		endcase
	end

	slpt_div #(
		.SUM_W (SUM_W),
		.Q_W   (Q_W),
		.CNT_W (CNT_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.rem_init  (div_rem),
		.steps     (div_steps),
		.den       (div_den),
		.busy      (div_busy),
		.quot      (div_quot)
	);

	always_ff @(posedge clk) begin
		if (cw.lat_avg) begin
			avg_q <= sample_sum_q[SUM_W-1:EXT_W];
		end
		if (cw.div_wait && !div_busy && cw.lat_ratio) begin
			ratio_q <= div_quot[LEVEL_W-1:0];
		end else if (cw.set_one) begin
			ratio_q <= Q15_ONE;
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	assign out_load = cw.out_load && !hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_raw_q <= s_q;
			out_avg_q <= avg_q;
			out_mag_q <= (s_q >= avg_q) ? s_q - avg_q : '0;
			out_adj_q <= ratio_q;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.raw_level      = out_raw_q;
	assign results.average_level  = out_avg_q;
	assign results.magnitude      = out_mag_q;
	assign results.adjusted_level = out_adj_q;

endmodule
